### hw/rtl/ps2mq_pkg.sv
// ----------------------------------------------------------------------------
// ps2mq_pkg
// Shared types, register indexes and cursor arithmetic for the PS/2 mouse
// packet decoder with its event queue.
// ----------------------------------------------------------------------------
package ps2mq_pkg;

    // Item kinds on the input stream
    typedef enum logic [1:0] {
        MODE_DATA  = 2'd0,   // byte from the mouse port
        MODE_FLUSH = 2'd1,   // controller buffer empty, burst ends
        MODE_READ  = 2'd2    // reader asks for one queued event
    } t_mode;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LEN    = 2'd2;

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 13;

    // Field widths
    localparam int POS_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int ENTRY_W = 32;   // status, x, y

    localparam logic [SIZE_W-1:0] SIZE_MAX  = 13'd4096;
    localparam logic [2:0]        LEN_SHORT = 3'd3;
    localparam logic [2:0]        LEN_LONG  = 3'd4;
    localparam logic [2:0]        BTN_MASK  = 3'd7;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [2:0]        pkt_len;
    } t_cfg;

    // Outcome of one accepted item in the packet framer
    typedef struct packed {
        logic               moved;   // packet completed with motion
        logic               push;    // button set, queue an event
        logic [ENTRY_W-1:0] entry;   // {y, x, status}
        logic [POS_W-1:0]   pos_x;   // cursor after this item
        logic [POS_W-1:0]   pos_y;
    } t_pkt_res;

    // Screen size with zero and oversize values pulled into range
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = 13'd1;
        end else if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end else begin
            r = s;
        end
        return r;
    endfunction

    // Move one axis by a signed delta and clamp to 0 .. size-1
    function automatic logic [POS_W-1:0] move_axis(input logic [POS_W-1:0] pos,
                                                   input logic [8:0]       delta,
                                                   input logic [SIZE_W-1:0] size);
        logic signed [13:0] n;
        logic signed [13:0] lim;
        logic [SIZE_W-1:0]  top;
        logic [POS_W-1:0]   r;
        n   = $signed({2'b00, pos}) + $signed({{5{delta[8]}}, delta});
        lim = $signed({1'b0, size});
        top = size - 13'd1;
        if (n >= lim) begin
            r = top[POS_W-1:0];
        end else if (n < 14'sd0) begin
            r = '0;
        end else begin
            r = n[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

### hw/rtl/ps2mq_ram.sv
// ----------------------------------------------------------------------------
// ps2mq_ram
// Event store: simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ps2mq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ps2mq_cursor.sv
// ----------------------------------------------------------------------------
// ps2mq_cursor
// Packet framer and cursor tracker: collects status, X and Y bytes, applies
// the motion with clamping and flags packets that carry a button press.
// ----------------------------------------------------------------------------
module ps2mq_cursor (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,      // item accepted this cycle
    input  ps2mq_pkg::t_mode       i_mode,
    input  logic [7:0]             i_byte,
    input  ps2mq_pkg::t_cfg        i_cfg,
    output ps2mq_pkg::t_pkt_res    o_res
);
    import ps2mq_pkg::*;

    logic [2:0]       r_cnt;
    logic [7:0]       r_status;
    logic [7:0]       r_dx;
    logic [7:0]       r_dy;
    logic [POS_W-1:0] r_pos_x;
    logic [POS_W-1:0] r_pos_y;

    logic [2:0]       n_cnt;
    logic [2:0]       cnt_inc;
    logic [2:0]       len_eff;
    logic             finish;
    logic [7:0]       dy_byte;
    logic [8:0]       dx_s;
    logic [8:0]       dy_s;
    logic             moved;
    logic [POS_W-1:0] n_pos_x;
    logic [POS_W-1:0] n_pos_y;

    // Packet length held to 3 or 4
    always_comb begin
        if (i_cfg.pkt_len < LEN_SHORT) begin
            len_eff = LEN_SHORT;
        end else if (i_cfg.pkt_len > LEN_LONG) begin
            len_eff = LEN_LONG;
        end else begin
            len_eff = i_cfg.pkt_len;
        end
    end

    assign cnt_inc = r_cnt + 3'd1;
    assign finish  = i_en && (i_mode == MODE_DATA) && (cnt_inc >= len_eff);

    // Y byte may arrive in the very cycle that completes the packet
    assign dy_byte = (r_cnt == 3'd2) ? i_byte : r_dy;
    assign dx_s    = {r_dx[7], r_dx};
    assign dy_s    = 9'd0 - {dy_byte[7], dy_byte};   // screen Y grows downwards
    assign moved   = finish && ((r_dx != 8'd0) || (dy_byte != 8'd0));

    // Cursor update with clamping
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (moved) begin
            n_pos_x = move_axis(r_pos_x, dx_s, eff_size(i_cfg.width));
            n_pos_y = move_axis(r_pos_y, dy_s, eff_size(i_cfg.height));
        end
    end

    // Byte counter
    always_comb begin
        n_cnt = r_cnt;
        if (i_en) begin
            case (i_mode)
                MODE_DATA:  n_cnt = finish ? 3'd0 : cnt_inc;
                MODE_FLUSH: n_cnt = 3'd0;
                default:    n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_status <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
        end else begin
            r_cnt   <= n_cnt;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            if (i_en && (i_mode == MODE_DATA)) begin
                case (r_cnt)
                    3'd0:    r_status <= i_byte;
                    3'd1:    r_dx     <= i_byte;
                    3'd2:    r_dy     <= i_byte;
                    default: r_dy     <= r_dy;   // wheel byte ignored
                endcase
            end
        end
    end

    // Result of this item
    always_comb begin
        o_res.moved = moved;
        o_res.push  = finish && ((r_status[2:0] & BTN_MASK) != 3'd0);
        o_res.entry = {n_pos_y, n_pos_x, r_status};
        o_res.pos_x = n_pos_x;
        o_res.pos_y = n_pos_y;
    end

endmodule

### hw/rtl/ps2_mouse_packet_cursor_queue.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_queue
// PS/2 mouse packet decoder: frames mouse bytes, tracks a clamped cursor and
// queues button events in a ring buffer that read transactions pop.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while m_axis_tready does not hold the
// output; the event RAM read port is registered, so each item passes one
// capture stage and one output register.
// Reset (synchronous, active low) clears cursor, framer, queue pointers and
// the output stage and loads 640 x 480, 3-byte packets; the event RAM is not
// cleared and no pass over it runs.
module ps2_mouse_packet_cursor_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ps2mq_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [ps2mq_pkg::CFG_DW-1:0]  i_cfg_wdata,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [7:0] data_byte, [8] is_top_window
    input  logic [1:0]                    s_axis_tuser,   // [1:0] mode
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,   // [7:0] event_status, [19:8] event_x,
                                                          // [31:20] event_y, [43:32] cursor_x,
                                                          // [55:44] cursor_y, [56] cursor_moved
    output logic [0:0]                    m_axis_tuser    // [0] event_valid
);
    import ps2mq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] IDX_LAST = AW'(QUEUE_DEPTH - 1);

    t_cfg             r_cfg;
    t_mode            in_mode;
    t_pkt_res         res;
    logic             accept;
    logic             pop;
    logic [AW-1:0]    r_wr_idx;
    logic [AW-1:0]    r_rd_idx;
    logic [ENTRY_W-1:0] rd_data;

    logic             r_s1_valid;
    logic             r_s1_ev_valid;
    logic             r_s1_moved;
    logic [POS_W-1:0] r_s1_cx;
    logic [POS_W-1:0] r_s1_cy;
    logic             s1_adv;

    logic             r_m_valid;
    logic [63:0]      r_m_tdata;
    logic             r_m_tuser;
    logic [ENTRY_W-1:0] ev;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width   <= 13'd640;
            r_cfg.height  <= 13'd480;
            r_cfg.pkt_len <= LEN_SHORT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_cfg.width   <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg.height  <= i_cfg_wdata;
                CFG_LEN:    r_cfg.pkt_len <= i_cfg_wdata[2:0];
                default:    r_cfg         <= r_cfg;
            endcase
        end
    end

    // Handshake and pipeline advance
    assign s1_adv        = r_s1_valid && (!r_m_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_mode       = t_mode'(s_axis_tuser);

    // Pop only for the top window with a non-empty queue
    assign pop = accept && (in_mode == MODE_READ) && s_axis_tdata[8]
                 && (r_wr_idx != r_rd_idx);

    ps2mq_cursor u_cursor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_mode  (in_mode),
        .i_byte  (s_axis_tdata[7:0]),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Event store; a read never targets the entry written in the same cycle
    // when it matters, as a pop requires the queue to be non-empty
    ps2mq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .DW    (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && res.push),
        .i_waddr (r_wr_idx),
        .i_wdata (res.entry),
        .i_re    (accept),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    // Ring pointers, no overrun check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
        end else begin
            if (accept && res.push) begin
                r_wr_idx <= (r_wr_idx == IDX_LAST) ? '0 : r_wr_idx + AW'(1);
            end
            if (pop) begin
                r_rd_idx <= (r_rd_idx == IDX_LAST) ? '0 : r_rd_idx + AW'(1);
            end
        end
    end

    // Capture stage, waits for the RAM read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ev_valid <= pop;
            r_s1_moved    <= res.moved;
            r_s1_cx       <= res.pos_x;
            r_s1_cy       <= res.pos_y;
        end
    end

    // Output register
    assign ev = r_s1_ev_valid ? rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_adv) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_m_tdata <= {7'd0, r_s1_moved, r_s1_cy, r_s1_cx, ev};
            r_m_tuser <= r_s1_ev_valid;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_tdata;
    assign m_axis_tuser[0] = r_m_tuser;

`ifndef NO_ASSERTIONS
    // Every accepted item lands in the capture stage
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted transaction not captured");

    // Queue pointers stay inside the ring
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx <= IDX_LAST) && (r_rd_idx <= IDX_LAST))
        else $error("queue pointer out of range");

    // A result without an event carries zero event fields
    a_no_event_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !r_s1_ev_valid) |=> (m_axis_tdata[31:0] == 32'd0))
        else $error("event fields not cleared");

    // Read pointer moves only on a pop of a non-empty queue
    a_pop_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop |=> $stable(r_rd_idx))
        else $error("read pointer moved without a pop");
`endif

endmodule

### test/ps2_mouse_packet_cursor_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_queue_test
// Self-checking bench for the PS/2 mouse packet decoder. A short stimulus
// table covers the edge cases, then randomised phases push framed packets,
// noise and read transactions under several screen and packet settings.
// Each result is compared against its table value or a cycle-free model of the decoder.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_queue_test;
    import ps2mq_pkg::*;

    localparam logic [1:0] MODE_IDLE  = 2'd3;   // unused kind, cursor echoed
    localparam int         EVQ_DEPTH  = 64;
    localparam int         IDLE_LIMIT = 2000;

    typedef struct packed {
        bit        ev_valid;
        bit [7:0]  ev_status;
        bit [11:0] ev_x;
        bit [11:0] ev_y;
        bit [11:0] cur_x;
        bit [11:0] cur_y;
        bit        moved;
    } t_mouse_result;

    typedef struct packed {
        bit            is_cfg;
        logic [1:0]    reg_idx;
        logic [12:0]   reg_val;
        logic [1:0]    mode;
        logic [7:0]    byte_in;
        logic          top;
        bit            known;
        t_mouse_result want;
    } t_stim_row;

    // DUT signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_addr = '0;
    logic [12:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [7:0] data_byte, [8] is_top_window
    logic [1:0]  s_axis_tuser = '0;    // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [63:0] m_axis_tdata;         // [7:0] event_status, [19:8] event_x,
                                       // [31:20] event_y, [43:32] cursor_x,
                                       // [55:44] cursor_y, [56] cursor_moved
    logic [0:0]  m_axis_tuser;         // [0] event_valid

    // Decoder model state
    logic [12:0] scr_w = 13'd640;
    logic [12:0] scr_h = 13'd480;
    logic [2:0]  pkt_len = 3'd3;
    logic [2:0]  pkt_count = '0;
    logic [7:0]  pkt_status = '0;
    logic [7:0]  pkt_dx = '0;
    logic [7:0]  pkt_dy = '0;
    logic [11:0] cur_x = '0;
    logic [11:0] cur_y = '0;
    logic [7:0]  evq_status [EVQ_DEPTH];
    logic [11:0] evq_x [EVQ_DEPTH];
    logic [11:0] evq_y [EVQ_DEPTH];
    logic [5:0]  evq_wr = '0;
    logic [5:0]  evq_rd = '0;

    t_mouse_result pending_results [$];
    t_stim_row     dir_rows [$];
    int            fail_count = 0;
    int            item_count = 0;
    int            burst_left = 0;
    int            idle_cycles = 0;
    int            stall_left = 0;
    int            stall_style = 0;
    int            style_left = 0;
    int            phase_reads [8] = '{30, 0, 60, 20, 35, 10, 45, 25};
    int            phase_items [8] = '{70, 260, 60, 60, 60, 60, 60, 60};

    ps2_mouse_packet_cursor_queue i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // One cursor axis: add the delta and pin to 0 .. size-1
    function automatic logic [11:0] clamp_axis(input logic [11:0] pos, input int delta,
                                               input int size);
        int n;
        n = int'(pos) + delta;
        if (n >= size) begin
            n = size - 1;
        end else if (n < 0) begin
            n = 0;
        end
        return n[11:0];
    endfunction

    // Cursor and event queue outcome of one accepted item
    function automatic t_mouse_result decode_item(input logic [1:0] mode, input logic [7:0] b,
                                                  input logic top);
        t_mouse_result r;
        int            len;
        int            dx;
        int            dy;
        int            wsz;
        int            hsz;
        r   = '0;
        len = (pkt_len < 3'd3) ? 3 : ((pkt_len > 3'd4) ? 4 : int'(pkt_len));
        wsz = (scr_w == 13'd0) ? 1 : ((scr_w > 13'd4096) ? 4096 : int'(scr_w));
        hsz = (scr_h == 13'd0) ? 1 : ((scr_h > 13'd4096) ? 4096 : int'(scr_h));
        if (mode == MODE_DATA) begin
            case (pkt_count)
                3'd0: pkt_status = b;
                3'd1: pkt_dx = b;
                3'd2: pkt_dy = b;
                default: ;    // wheel byte, dropped
            endcase
            pkt_count = pkt_count + 3'd1;
            if (int'(pkt_count) >= len) begin
                pkt_count = '0;
                dx = int'($signed(pkt_dx));
                dy = int'($signed(pkt_dy));
                dy = -dy;    // screen Y grows downwards
                r.moved = (dx != 0) || (dy != 0);
                if (r.moved) begin
                    cur_x = clamp_axis(cur_x, dx, wsz);
                    cur_y = clamp_axis(cur_y, dy, hsz);
                end
                // any button held queues an event, overrun is not guarded
                if (pkt_status[2:0] != 3'b000) begin
                    evq_status[evq_wr] = pkt_status;
                    evq_x[evq_wr]      = cur_x;
                    evq_y[evq_wr]      = cur_y;
                    evq_wr             = evq_wr + 6'd1;
                end
            end
        end else if (mode == MODE_FLUSH) begin
            pkt_count = '0;
        end else if (mode == MODE_READ) begin
            if (top && evq_wr != evq_rd) begin
                r.ev_valid  = 1'b1;
                r.ev_status = evq_status[evq_rd];
                r.ev_x      = evq_x[evq_rd];
                r.ev_y      = evq_y[evq_rd];
                evq_rd      = evq_rd + 6'd1;
            end
        end
        r.cur_x = cur_x;
        r.cur_y = cur_y;
        return r;
    endfunction

    // Stimulus table entries
    function automatic void row_cfg(input logic [1:0] idx, input logic [12:0] val);
        t_stim_row r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_item(input logic [1:0] mode, input logic [7:0] b,
                                     input logic top);
        t_stim_row r;
        r         = '0;
        r.mode    = mode;
        r.byte_in = b;
        r.top     = top;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_known(input logic [1:0] mode, input logic [7:0] b,
                                      input logic top, input bit ev, input bit [7:0] st,
                                      input bit [11:0] ex, ey, cx, cy, input bit mv);
        t_stim_row r;
        r         = '0;
        r.mode    = mode;
        r.byte_in = b;
        r.top     = top;
        r.known   = 1'b1;
        r.want    = '{ev, st, ex, ey, cx, cy, mv};
        dir_rows.push_back(r);
    endfunction

    // Motion byte biased towards zero and the extremes
    function automatic logic [7:0] pick_delta();
        logic [7:0] d;
        case ($urandom_range(0, 5))
            0, 1: d = 8'h00;
            2: begin
                case ($urandom_range(0, 3))
                    0: d = 8'h7F;
                    1: d = 8'h80;
                    2: d = 8'h01;
                    default: d = 8'hFF;
                endcase
            end
            default: d = 8'($urandom_range(0, 255));
        endcase
        return d;
    endfunction

    // Send one transaction in bursts, then record what it should produce
    task automatic send_item(input logic [1:0] mode, input logic [7:0] b, input logic top,
                             input bit known, input t_mouse_result want);
        t_mouse_result calc;
        int            gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, top, b};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        calc = decode_item(mode, b, top);
        pending_results.push_back(known ? want : calc);
        if (mode != MODE_IDLE) begin
            item_count++;
        end
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:  scr_w = val;
            CFG_HEIGHT: scr_h = val;
            CFG_LEN:    pkt_len = val[2:0];
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_results
        t_mouse_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: tdata 0x%016h", m_axis_tdata);
                fail_count++;
            end else begin
                w = pending_results.pop_front();
                check_field("event_valid",  32'(w.ev_valid),  32'(m_axis_tuser[0]));
                check_field("event_status", 32'(w.ev_status), 32'(m_axis_tdata[7:0]));
                check_field("event_x",      32'(w.ev_x),      32'(m_axis_tdata[19:8]));
                check_field("event_y",      32'(w.ev_y),      32'(m_axis_tdata[31:20]));
                check_field("cursor_x",     32'(w.cur_x),     32'(m_axis_tdata[43:32]));
                check_field("cursor_y",     32'(w.cur_y),     32'(m_axis_tdata[55:44]));
                check_field("cursor_moved", 32'(w.moved),     32'(m_axis_tdata[56]));
            end
        end
    end

    // Receiver back-pressure: quiet, light and heavy stretches picked at random
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            style_left  <= $urandom_range(50, 300);
            stall_style <= $urandom_range(0, 2);
        end else begin
            style_left <= style_left - 1;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (stall_style == 1 && $urandom_range(0, 7) == 0) begin
                stall_left <= $urandom_range(1, 4);
            end else if (stall_style == 2 && $urandom_range(0, 2) == 0) begin
                stall_left <= $urandom_range(1, 24);
            end
        end
    end

    // Watchdog: no transaction on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("ps2_mouse_packet_cursor_queue test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_stim_row     row;
        t_mouse_result no_want;
        logic [12:0]   w;
        logic [12:0]   h;
        logic [2:0]    l;
        logic [7:0]    st;
        logic [7:0]    b;
        int            plen;
        int            nb;
        int            target;
        int            pick;
        int            rd;
        int            btn_pct;

        no_want = '0;

        // Edge cases at the reset settings (640 x 480, 3-byte packets)
        row_known(MODE_READ,  8'h00, 1'b1, 0, 8'h00, 0, 0, 0, 0, 0);      // empty queue
        row_known(MODE_IDLE,  8'hFF, 1'b1, 0, 8'h00, 0, 0, 0, 0, 0);
        row_known(MODE_DATA,  8'h00, 1'b0, 0, 8'h00, 0, 0, 0, 0, 0);
        row_known(MODE_FLUSH, 8'hFF, 1'b1, 0, 8'h00, 0, 0, 0, 0, 0);      // partial dropped
        row_known(MODE_DATA,  8'h01, 1'b0, 0, 8'h00, 0, 0, 0, 0, 0);
        row_known(MODE_DATA,  8'h7F, 1'b1, 0, 8'h00, 0, 0, 0, 0, 0);
        row_known(MODE_DATA,  8'h80, 1'b0, 0, 8'h00, 0, 0, 127, 128, 1);
        row_known(MODE_READ,  8'hFF, 1'b0, 0, 8'h00, 0, 0, 127, 128, 0); // not on top
        row_known(MODE_READ,  8'h00, 1'b1, 1, 8'h01, 127, 128, 127, 128, 0);
        // most negative X delta clamps to the left edge
        row_known(MODE_DATA,  8'h07, 1'b0, 0, 8'h00, 0, 0, 127, 128, 0);
        row_known(MODE_DATA,  8'h80, 1'b0, 0, 8'h00, 0, 0, 127, 128, 0);
        row_known(MODE_DATA,  8'h7F, 1'b0, 0, 8'h00, 0, 0, 0, 1, 1);
        // no motion, no buttons
        row_known(MODE_DATA,  8'h08, 1'b0, 0, 8'h00, 0, 0, 0, 1, 0);
        row_known(MODE_DATA,  8'h00, 1'b0, 0, 8'h00, 0, 0, 0, 1, 0);
        row_known(MODE_DATA,  8'h00, 1'b0, 0, 8'h00, 0, 0, 0, 1, 0);
        // zero width, oversize height, wheel packets
        row_cfg(CFG_WIDTH, 13'd0);
        row_cfg(CFG_HEIGHT, 13'd8191);
        row_cfg(CFG_LEN, 13'd4);
        row_item(MODE_DATA, 8'hFF, 1'b1);
        row_item(MODE_DATA, 8'h01, 1'b0);
        row_item(MODE_DATA, 8'hFF, 1'b1);
        row_item(MODE_DATA, 8'hAA, 1'b0);
        // length shortened with three bytes already taken
        row_item(MODE_DATA, 8'h02, 1'b0);
        row_item(MODE_DATA, 8'h00, 1'b0);
        row_item(MODE_DATA, 8'h00, 1'b0);
        row_cfg(CFG_LEN, 13'd3);
        row_item(MODE_DATA, 8'h55, 1'b1);
        row_known(MODE_READ, 8'h3C, 1'b1, 1, 8'h07, 0, 1, 0, 2, 0);
        row_item(MODE_READ, 8'hC3, 1'b1);
        row_item(MODE_READ, 8'h00, 1'b1);
        row_known(MODE_READ, 8'hFF, 1'b1, 0, 8'h00, 0, 0, 0, 2, 0);

        // Reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.mode, row.byte_in, row.top, row.known, row.want);
            end
        end

        // Random phases, each under its own screen and packet setting
        for (int ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0: begin w = 13'd640;  h = 13'd480;  l = 3'd4; end
                1: begin w = 13'd1;    h = 13'd1;    l = 3'd3; end    // queue laps here
                2: begin w = 13'd4096; h = 13'd4096; l = 3'd4; end
                3: begin w = 13'd0;    h = 13'd8191; l = 3'd0; end
                4: begin w = 13'd13;   h = 13'd7;    l = 3'd7; end
                5: begin
                    w = 13'($urandom_range(1, 300));
                    h = 13'($urandom_range(1, 300));
                    l = 3'($urandom_range(3, 4));
                end
                6: begin
                    w = 13'($urandom_range(1, 8191));
                    h = 13'($urandom_range(1, 8191));
                    l = 3'($urandom_range(0, 7));
                end
                default: begin w = 13'd8191; h = 13'd0; l = 3'd3; end
            endcase
            write_reg(CFG_WIDTH, w);
            write_reg(CFG_HEIGHT, h);
            write_reg(CFG_LEN, {10'd0, l});
            plen    = (l < 3'd3) ? 3 : ((l > 3'd4) ? 4 : int'(l));
            rd      = phase_reads[ph];
            btn_pct = (ph == 1) ? 100 : 70;
            target  = item_count + phase_items[ph];
            while (item_count < target) begin
                pick = $urandom_range(0, 99);
                if (pick < rd) begin
                    send_item(MODE_READ, 8'($urandom_range(0, 255)), $urandom_range(0, 4) != 0,
                              1'b0, no_want);
                end else if (pick < rd + 3) begin
                    send_item(MODE_FLUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0, no_want);
                end else if (pick < rd + 5) begin
                    send_item(MODE_IDLE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0, no_want);
                end else if (pick < rd + 9) begin
                    // stray byte, knocks the framing out of step
                    send_item(MODE_DATA, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'b0, no_want);
                end else begin
                    st = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 99) < btn_pct) begin
                        st[3'($urandom_range(0, 2))] = 1'b1;
                    end else begin
                        st[2:0] = 3'b000;
                    end
                    // now and then a packet cut short
                    nb = ($urandom_range(0, 9) == 0) ? $urandom_range(1, plen - 1) : plen;
                    for (int k = 0; k < nb; k++) begin
                        case (k)
                            0:       b = st;
                            1, 2:    b = pick_delta();
                            default: b = 8'($urandom_range(0, 255));
                        endcase
                        send_item(MODE_DATA, b, 1'($urandom_range(0, 1)), 1'b0, no_want);
                    end
                    if (nb < plen && $urandom_range(0, 1) == 1) begin
                        send_item(MODE_FLUSH, 8'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), 1'b0, no_want);
                    end
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ps2_mouse_packet_cursor_queue test passed");
        end else begin
            $display("ps2_mouse_packet_cursor_queue test failed");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/ps2mq_pkg.sv
hw/rtl/ps2mq_ram.sv
hw/rtl/ps2mq_cursor.sv
hw/rtl/ps2_mouse_packet_cursor_queue.sv
test/ps2_mouse_packet_cursor_queue_test.sv
